/* hw/rtl/vbc_pkg.sv */
// ----------------------------------------------------------------------------
// vbc_pkg - shared types and microcode for the breath cycle controller
// Control word layout, sequencer step codes, jump conditions, and the
// structs that pass between sequencer, datapath and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vbc_pkg;

	// Sequencer steps
	localparam int unsigned STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_WAIT   = 3'd0;
	localparam step_t STEP_CONV   = 3'd1;
	localparam step_t STEP_START  = 3'd2;
	localparam step_t STEP_DIV    = 3'd3;
	localparam step_t STEP_LEN    = 3'd4;
	localparam step_t STEP_INSP   = 3'd5;
	localparam step_t STEP_FINISH = 3'd6;
	localparam step_t STEP_EMIT   = 3'd7;

	// Jump conditions
	typedef logic [2:0] cond_t;

	localparam cond_t COND_NONE     = 3'd0;
	localparam cond_t COND_NO_IN    = 3'd1;
	localparam cond_t COND_RUNNING  = 3'd2;
	localparam cond_t COND_DIV_MORE = 3'd3;
	localparam cond_t COND_OUT_BUSY = 3'd4;

	// Register indexes of the configuration port
	typedef logic [2:0] cfg_index_t;

	localparam cfg_index_t CFG_RATE      = 3'd0;
	localparam cfg_index_t CFG_OPENING   = 3'd1;
	localparam cfg_index_t CFG_PEAK_LIM  = 3'd2;
	localparam cfg_index_t CFG_PLAT_LIM  = 3'd3;
	localparam cfg_index_t CFG_PEP_MIN   = 3'd4;
	localparam cfg_index_t CFG_EXP_ANGLE = 3'd5;

	typedef struct packed {
		logic  take;     // input transfer allowed in this step
		logic  conv;     // pressure conversion multiply
		logic  start;    // cycle start: latch settings, clear captures, close valves, arm divider
		logic  div;      // one restoring divide step
		logic  ld_len;   // load cycle length, multiply for the third
		logic  ld_insp;  // load inspiration length
		logic  finish;   // sign-correct pressure, advance tick count
		logic  emit;     // phase decision, state update, result load
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	typedef struct packed {
		logic in_fire;
		logic running;
		logic div_more;
		logic out_busy;
	} seq_status_t;

	typedef struct packed {
		logic running;
		logic div_more;
	} dp_flags_t;

	typedef struct packed {
		logic [5:0] rate;
		logic [5:0] opening;
		logic [6:0] peak_lim;
		logic [4:0] plat_lim;
		logic [4:0] pep_min;
		logic [7:0] exp_angle;
	} cfg_t;

	typedef struct packed {
		logic signed [10:0] pressure;
		logic [1:0]         phase;
		logic [7:0]         blower_angle;
		logic               blower_update;
		logic [7:0]         patient_angle;
		logic               patient_update;
		logic signed [10:0] peak;
		logic signed [10:0] plateau;
		logic signed [10:0] pep;
		logic [10:0]        tick;
		logic               cycle_end;
	} result_t;

	// Control store: one word per step
	function automatic ctrl_word_t ucode_rom(input step_t step);
		ctrl_word_t w;
		w = '0;
		unique case (step)
			STEP_WAIT: begin
				w.take   = 1'b1;
				w.cond   = COND_NO_IN;
				w.target = STEP_WAIT;
			end
			STEP_CONV: begin
				w.conv   = 1'b1;
				w.cond   = COND_RUNNING;
				w.target = STEP_FINISH;
			end
			STEP_START: begin
				w.start = 1'b1;
			end
			STEP_DIV: begin
				w.div    = 1'b1;
				w.cond   = COND_DIV_MORE;
				w.target = STEP_DIV;
			end
			STEP_LEN: begin
				w.ld_len = 1'b1;
			end
			STEP_INSP: begin
				w.ld_insp = 1'b1;
			end
			STEP_FINISH: begin
				w.finish = 1'b1;
			end
			STEP_EMIT: begin
				w.emit   = 1'b1;
				w.cond   = COND_OUT_BUSY;
				w.target = STEP_EMIT;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/ventilator_breath_cycle_controller_top.sv */
// ----------------------------------------------------------------------------
// ventilator_breath_cycle_controller_top - breath cycle controller
// Stream in raw pressure ticks, stream out phase, valve angles and captures.
// ----------------------------------------------------------------------------
// Each input transfer is one 10 ms tick carrying a 10-bit pressure ADC
// reading; each tick yields exactly one result transfer with the converted
// pressure in cmH2O, the breathing phase (in tuser), the blower and patient
// valve angles with their change flags, the peak, plateau and PEP captures
// and the tick index, with tlast marking the final tick of a breathing
// cycle. After an input transfer the microcoded sequencer runs the
// conversion, finish and emit steps, then is ready for input again; the
// result register loads in the emit step and the next tick can be taken
// while that result waits. The first tick of a breathing cycle adds the
// start step and the 13-step restoring divide of 6000 by the breath rate.
// Configuration writes take effect on the next clock; rate, blower
// opening, plateau limit and PEP minimum are sampled at each cycle start,
// while the peak limit and expiration angle act on the next tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ventilator_breath_cycle_controller_top (
	input  wire         clk,
	input  wire         arst_n,
	// configuration write port
	input  wire         cfg_wen,
	input  wire  [2:0]  cfg_index,
	input  wire  [7:0]  cfg_wdata,
	// input stream
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [15:0] s_axis_tdata,  // [9:0] pressure_sample
	// output stream
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// [10:0] pressure, [18:11] blower_angle, [19] blower_update,
	// [27:20] patient_angle, [28] patient_update, [39:29] peak_capture,
	// [50:40] plateau_capture, [61:51] pep_capture, [72:62] tick_index
	output logic [79:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,  // [1:0] phase
	output logic        m_axis_tlast   // cycle_end
);
	import vbc_pkg::*;

	// register reset values
	localparam logic [5:0] RST_RATE      = 6'd20;
	localparam logic [5:0] RST_OPENING   = 6'd45;
	localparam logic [6:0] RST_PEAK_LIM  = 7'd60;
	localparam logic [4:0] RST_PLAT_LIM  = 5'd30;
	localparam logic [4:0] RST_PEP_MIN   = 5'd5;
	localparam logic [7:0] RST_EXP_ANGLE = 8'd45;

	cfg_t        cfg_q;
	ctrl_word_t  cw;
	seq_status_t status;
	dp_flags_t   flags;
	result_t     res;
	logic        out_valid_q;
	logic        in_fire;
	logic        emit_en;

	// Configuration registers; writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate      <= RST_RATE;
			cfg_q.opening   <= RST_OPENING;
			cfg_q.peak_lim  <= RST_PEAK_LIM;
			cfg_q.plat_lim  <= RST_PLAT_LIM;
			cfg_q.pep_min   <= RST_PEP_MIN;
			cfg_q.exp_angle <= RST_EXP_ANGLE;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_RATE:      cfg_q.rate      <= cfg_wdata[5:0];
				CFG_OPENING:   cfg_q.opening   <= cfg_wdata[5:0];
				CFG_PEAK_LIM:  cfg_q.peak_lim  <= cfg_wdata[6:0];
				CFG_PLAT_LIM:  cfg_q.plat_lim  <= cfg_wdata[4:0];
				CFG_PEP_MIN:   cfg_q.pep_min   <= cfg_wdata[4:0];
				CFG_EXP_ANGLE: cfg_q.exp_angle <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input is taken only in the wait step of the program
	assign s_axis_tready = cw.take;
	assign in_fire       = s_axis_tvalid && cw.take;

	// Hold the emit step until the result register is free
	assign emit_en = cw.emit && !out_valid_q;

	assign status.in_fire  = in_fire;
	assign status.running  = flags.running;
	assign status.div_more = flags.div_more;
	assign status.out_busy = out_valid_q;

	vbc_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cw     (cw)
	);

	vbc_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cw      (cw),
		.in_fire (in_fire),
		.sample  (s_axis_tdata[9:0]),
		.emit_en (emit_en),
		.cfg     (cfg_q),
		.flags   (flags),
		.res     (res)
	);

	// Result register valid: set on load, drop on output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_en) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, res.tick, res.pep, res.plateau, res.peak,
	                        res.patient_update, res.patient_angle,
	                        res.blower_update, res.blower_angle, res.pressure};
	assign m_axis_tuser  = res.phase;
	assign m_axis_tlast  = res.cycle_end;

endmodule

`default_nettype wire

/* hw/rtl/vbc_sequencer.sv */
// ----------------------------------------------------------------------------
// vbc_sequencer - step counter and control store
// Fetches one control word per step and resolves conditional jumps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vbc_sequencer (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire vbc_pkg::seq_status_t status,
	output vbc_pkg::ctrl_word_t      cw
);
	import vbc_pkg::*;

	step_t step_q;
	step_t step_d;
	logic  jump;

	assign cw = ucode_rom(step_q);

	always_comb begin
		unique case (cw.cond)
			COND_NONE:     jump = 1'b0;
			COND_NO_IN:    jump = !status.in_fire;
			COND_RUNNING:  jump = status.running;
			COND_DIV_MORE: jump = status.div_more;
			COND_OUT_BUSY: jump = status.out_busy;
			default:       jump = 1'b0;
		endcase
		// fall through wraps from the last step back to the wait step
		step_d = jump ? cw.target : step_t'(step_q + 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

	// The divide loop is entered only from the cycle start step
	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_DIV) |->
		($past(step_q) == STEP_START || $past(step_q) == STEP_DIV))
		else $error("divide step entered out of sequence");

	// Input is taken only in the wait step, and a transfer always moves on
	a_take_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(status.in_fire && step_q == STEP_WAIT) |=> (step_q == STEP_CONV))
		else $error("accepted tick did not start conversion");

endmodule

`default_nettype wire

/* hw/rtl/vbc_datapath.sv */
// ----------------------------------------------------------------------------
// vbc_datapath - pressure conversion, cycle timing and valve control
// Holds the breath state and result register; every action is gated by
// the control word from the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vbc_datapath (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire vbc_pkg::ctrl_word_t cw,
	input  wire                      in_fire,
	input  wire  [9:0]               sample,
	input  wire                      emit_en,
	input  wire vbc_pkg::cfg_t       cfg,
	output vbc_pkg::dp_flags_t       flags,
	output vbc_pkg::result_t         res
);
	import vbc_pkg::*;

	localparam logic [1:0] PH_PUSH     = 2'd0;
	localparam logic [1:0] PH_HOLD     = 2'd1;
	localparam logic [1:0] PH_EXP      = 2'd2;
	localparam logic [1:0] PH_EXP_HOLD = 2'd3;

	localparam logic signed [10:0] ADC_OFFSET = 11'sd194;
	// ceil(2^20 / 17) and ceil(2^17 / 3): exact over the operand ranges used
	localparam logic [15:0] RECIP17 = 16'd61681;
	localparam logic [15:0] RECIP3  = 16'd43691;
	localparam logic [12:0] TICKS_PER_MIN = 13'd6000;
	localparam logic [3:0]  DIV_STEPS = 4'd13;
	localparam logic [5:0]  RATE_MIN = 6'd5;
	localparam logic [5:0]  RATE_MAX = 6'd35;
	localparam logic [7:0]  POS_CLOSED = 8'd90;
	localparam logic signed [9:0] A_CLOSED = 10'sd90;
	localparam logic signed [9:0] A_OPEN   = 10'sd135;
	localparam logic signed [9:0] A_MAX    = 10'sd180;
	localparam logic signed [10:0] CAPTURE_NONE = -11'sd1;

	logic [9:0]         sample_q;
	logic               neg_q;
	logic [30:0]        prod_q;
	logic signed [10:0] p_q;
	logic [10:0]        tick_q;
	logic [10:0]        len_q;
	logic [8:0]         insp_q;
	logic signed [10:0] peak_q;
	logic signed [10:0] plat_q;
	logic signed [10:0] pep_q;
	logic [7:0]         blow_q;
	logic [7:0]         pat_q;
	logic [5:0]         lat_open_q;
	logic [4:0]         lat_plat_q;
	logic [4:0]         lat_pep_q;
	logic [6:0]         rem_q;
	logic [12:0]        quo_q;
	logic [5:0]         den_q;
	logic [3:0]         cnt_q;
	logic [26:0]        m3_q;
	result_t            res_q;

	function automatic logic [7:0] sat_angle(input logic signed [9:0] a);
		logic [7:0] r;
		priority if (a < 10'sd0) begin
			r = 8'd0;
		end else if (a > A_MAX) begin
			r = 8'd180;
		end else begin
			r = a[7:0];
		end
		return r;
	endfunction

	// Conversion: trunc((adc - 194) * 20 / 17) as sign and magnitude
	logic signed [10:0] diff;
	logic               diff_neg;
	logic [9:0]         mag;
	logic [14:0]        mag20;
	logic [30:0]        prod_d;
	logic [9:0]         q_mag;
	logic signed [10:0] p_d;

	assign diff     = $signed({1'b0, sample_q}) - ADC_OFFSET;
	assign diff_neg = diff[10];
	assign mag      = diff_neg ? 10'(-diff) : diff[9:0];
	assign mag20    = 15'({mag, 4'b0}) + 15'({mag, 2'b0});
	assign prod_d   = 31'(mag20) * 31'(RECIP17);
	assign q_mag    = prod_q[29:20];
	assign p_d      = neg_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

	// Restoring divider, one quotient bit per step
	logic [7:0] trial;
	logic       fits;
	logic [6:0] rem_d;
	logic [5:0] rate_sat;

	assign trial = {rem_q, quo_q[12]};
	assign fits  = trial >= {2'b0, den_q};
	assign rem_d = fits ? 7'(trial - {2'b0, den_q}) : trial[6:0];

	always_comb begin
		priority if (cfg.rate < RATE_MIN) begin
			rate_sat = RATE_MIN;
		end else if (cfg.rate > RATE_MAX) begin
			rate_sat = RATE_MAX;
		end else begin
			rate_sat = cfg.rate;
		end
	end

	assign flags.running  = (tick_q != 11'd0);
	assign flags.div_more = (cnt_q != 4'd1);

	// Phase decision and safety overrides
	logic [1:0]         phase;
	logic signed [9:0]  blow_w;
	logic signed [9:0]  pat_w;
	logic signed [10:0] peak_n;
	logic signed [10:0] plat_n;
	logic signed [10:0] pep_n;
	logic [7:0]         blow_s;
	logic [7:0]         pat_s;
	logic               last;

	always_comb begin
		peak_n = peak_q;
		plat_n = plat_q;
		pep_n  = pep_q;
		if (tick_q <= 11'(insp_q)) begin
			if (p_q >= peak_q) begin
				phase  = PH_PUSH;
				peak_n = p_q;
				blow_w = A_CLOSED - $signed({4'b0, lat_open_q});
				pat_w  = A_OPEN;
			end else begin
				phase  = PH_HOLD;
				plat_n = p_q;
				blow_w = A_OPEN;
				pat_w  = A_CLOSED;
			end
		end else begin
			phase  = PH_EXP;
			pep_n  = p_q;
			blow_w = A_OPEN;
			pat_w  = $signed({2'b0, cfg.exp_angle});
		end
		// peak limit: step the blower closed
		if (p_q > $signed({4'b0, cfg.peak_lim})) begin
			blow_w = $signed({2'b0, blow_q}) - 10'sd2;
		end
		// plateau limit: open the patient valve one degree
		if (phase == PH_HOLD && p_q > $signed({6'b0, lat_plat_q})) begin
			pat_w = $signed({2'b0, pat_q}) + 10'sd1;
		end
		// below PEP minimum: close the patient valve, hold expiration
		if (p_q < $signed({6'b0, lat_pep_q})) begin
			pat_w = A_CLOSED;
			phase = PH_EXP_HOLD;
		end
		blow_s = sat_angle(blow_w);
		pat_s  = sat_angle(pat_w);
		last   = (tick_q >= len_q);
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_q <= sample;
		end
		if (cw.conv) begin
			neg_q  <= diff_neg;
			prod_q <= prod_d;
		end
		if (cw.ld_len) begin
			m3_q <= 27'(quo_q[10:0]) * 27'(RECIP3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q        <= '0;
			tick_q     <= '0;
			len_q      <= '0;
			insp_q     <= '0;
			peak_q     <= CAPTURE_NONE;
			plat_q     <= CAPTURE_NONE;
			pep_q      <= CAPTURE_NONE;
			blow_q     <= POS_CLOSED;
			pat_q      <= POS_CLOSED;
			lat_open_q <= '0;
			lat_plat_q <= '0;
			lat_pep_q  <= '0;
			rem_q      <= '0;
			quo_q      <= '0;
			den_q      <= '0;
			cnt_q      <= '0;
		end else begin
			if (cw.start) begin
				lat_open_q <= cfg.opening;
				lat_plat_q <= cfg.plat_lim;
				lat_pep_q  <= cfg.pep_min;
				peak_q     <= CAPTURE_NONE;
				plat_q     <= CAPTURE_NONE;
				pep_q      <= CAPTURE_NONE;
				blow_q     <= POS_CLOSED;
				pat_q      <= POS_CLOSED;
				den_q      <= rate_sat;
				rem_q      <= '0;
				quo_q      <= TICKS_PER_MIN;
				cnt_q      <= DIV_STEPS;
			end
			if (cw.div) begin
				rem_q <= rem_d;
				quo_q <= {quo_q[11:0], fits};
				cnt_q <= cnt_q - 4'd1;
			end
			if (cw.ld_len) begin
				len_q <= quo_q[10:0];
			end
			if (cw.ld_insp) begin
				insp_q <= m3_q[25:17];
			end
			if (cw.finish) begin
				p_q    <= p_d;
				tick_q <= tick_q + 11'd1;
			end
			if (emit_en) begin
				peak_q <= peak_n;
				plat_q <= plat_n;
				pep_q  <= pep_n;
				blow_q <= blow_s;
				pat_q  <= pat_s;
				if (last) begin
					tick_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			res_q.pressure       <= p_q;
			res_q.phase          <= phase;
			res_q.blower_angle   <= blow_s;
			res_q.blower_update  <= (blow_s != blow_q);
			res_q.patient_angle  <= pat_s;
			res_q.patient_update <= (pat_s != pat_q);
			res_q.peak           <= peak_n;
			res_q.plateau        <= plat_n;
			res_q.pep            <= pep_n;
			res_q.tick           <= tick_q;
			res_q.cycle_end      <= last;
		end
	end

	assign res = res_q;

	// A result is never produced outside the current cycle
	a_tick_in_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		emit_en |-> (tick_q != 11'd0 && tick_q <= len_q))
		else $error("tick index outside breathing cycle");

	// Inspiration is the floor of one third of the cycle
	a_insp_third: assert property (@(posedge clk) disable iff (!arst_n)
		emit_en |-> (12'(insp_q) * 12'd3 <= 12'(len_q) &&
		             12'(len_q) < 12'(insp_q) * 12'd3 + 12'd3))
		else $error("inspiration length is not a third of cycle length");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking testbench for the breath cycle controller
// Feeds pressure ticks through the input stream and checks every result
// transfer against a per-tick prediction of phase, valve angles,
// captures and tick position. A short directed burst comes first. Random
// breath-shaped pressure traces follow, one breathing cycle per register
// setting with stalls on both streams, then a partial cycle without stalls.
// ----------------------------------------------------------------------------

module tb_top;
	import vbc_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 12;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 16;
	localparam int ANGLE_CLOSED  = 90;
	localparam int ANGLE_WIDE    = 45;
	localparam int ANGLE_TOP     = 180;
	localparam int TICKS_PER_MIN = 6000;
	localparam int RATE_LO       = 5;
	localparam int RATE_HI       = 35;
	localparam int ADC_ZERO      = 194;
	localparam int PRINT_CAP     = 100;

	typedef enum logic [1:0] {
		PH_PUSH      = 2'd0,
		PH_INSP_HOLD = 2'd1,
		PH_EXPIRE    = 2'd2,
		PH_EXP_HOLD  = 2'd3
	} phase_e;

	typedef enum int {WAVE_RISE, WAVE_STEADY, WAVE_FALL, WAVE_NOISE} wave_e;

	// ------------------------------------------------------------------------
	// Scoreboard: tracks the controller state per tick and holds the results
	// still owed by the block, oldest first.
	// ------------------------------------------------------------------------
	class breath_scoreboard;
		logic [5:0]  rate, opening;
		logic [6:0]  peak_lim;
		logic [4:0]  plat_lim, pep_min;
		logic [7:0]  exp_angle;
		logic [10:0] tick_cnt;
		int          cyc_len, insp_len;
		int          peak, plateau, pep;
		int          blow_pos, pat_pos;
		int          lat_open, lat_plat, lat_pep;
		result_t     due_results[$];
		int          errors;

		function new();
			rate      = 6'd20;
			opening   = 6'd45;
			peak_lim  = 7'd60;
			plat_lim  = 5'd30;
			pep_min   = 5'd5;
			exp_angle = 8'd45;
			tick_cnt  = '0;
			cyc_len   = 0;
			insp_len  = 0;
			peak      = -1;
			plateau   = -1;
			pep       = -1;
			blow_pos  = ANGLE_CLOSED;
			pat_pos   = ANGLE_CLOSED;
			lat_open  = 0;
			lat_plat  = 0;
			lat_pep   = 0;
			errors    = 0;
		endfunction

		function void set_reg(cfg_index_t idx, logic [7:0] value);
			case (idx)
				CFG_RATE:      rate      = value[5:0];
				CFG_OPENING:   opening   = value[5:0];
				CFG_PEAK_LIM:  peak_lim  = value[6:0];
				CFG_PLAT_LIM:  plat_lim  = value[4:0];
				CFG_PEP_MIN:   pep_min   = value[4:0];
				CFG_EXP_ANGLE: exp_angle = value;
				default: ;
			endcase
		endfunction

		function int clamp_angle(int a);
			if (a < 0)
				return 0;
			if (a > ANGLE_TOP)
				return ANGLE_TOP;
			return a;
		endfunction

		// Work out the result of one accepted pressure tick.
		function void predict_tick(logic [9:0] adc);
			int      p, r, blow, pat;
			phase_e  ph;
			result_t res;
			p = ((int'(adc) - ADC_ZERO) * 600 / 51) / 10;
			// cycle start: latch settings, clear captures, close both valves
			if (tick_cnt == 0) begin
				r = rate;
				if (r < RATE_LO)
					r = RATE_LO;
				if (r > RATE_HI)
					r = RATE_HI;
				cyc_len  = TICKS_PER_MIN / r;
				insp_len = cyc_len / 3;
				lat_open = opening;
				lat_plat = plat_lim;
				lat_pep  = pep_min;
				peak     = -1;
				plateau  = -1;
				pep      = -1;
				blow_pos = ANGLE_CLOSED;
				pat_pos  = ANGLE_CLOSED;
			end
			tick_cnt = tick_cnt + 11'd1;

			if (tick_cnt <= insp_len) begin
				if (p >= peak) begin
					ph   = PH_PUSH;
					peak = p;
					blow = ANGLE_CLOSED - lat_open;
					pat  = ANGLE_CLOSED + ANGLE_WIDE;
				end else begin
					ph      = PH_INSP_HOLD;
					plateau = p;
					blow    = ANGLE_CLOSED + ANGLE_WIDE;
					pat     = ANGLE_CLOSED;
				end
			end else begin
				ph   = PH_EXPIRE;
				pep  = p;
				blow = ANGLE_CLOSED + ANGLE_WIDE;
				pat  = exp_angle;
			end

			// safety overrides, in order: peak, plateau, PEP
			if (p > int'(peak_lim))
				blow = blow_pos - 2;
			if (ph == PH_INSP_HOLD && p > lat_plat)
				pat = pat_pos + 1;
			if (p < lat_pep) begin
				pat = ANGLE_CLOSED;
				ph  = PH_EXP_HOLD;
			end
			blow = clamp_angle(blow);
			pat  = clamp_angle(pat);

			res.pressure       = p[10:0];
			res.phase          = ph;
			res.blower_angle   = blow[7:0];
			res.blower_update  = (blow != blow_pos);
			res.patient_angle  = pat[7:0];
			res.patient_update = (pat != pat_pos);
			res.peak           = peak[10:0];
			res.plateau        = plateau[10:0];
			res.pep            = pep[10:0];
			res.tick           = tick_cnt;
			res.cycle_end      = (tick_cnt >= cyc_len);
			blow_pos = blow;
			pat_pos  = pat;
			if (res.cycle_end)
				tick_cnt = '0;
			due_results.push_back(res);
		endfunction

		task report(string msg);
			if (errors < PRINT_CAP)
				$display("ERROR at %0t ns: %s", $time, msg);
			errors++;
		endtask

		task compare(string field, logic signed [31:0] got, logic signed [31:0] want);
			if (got !== want)
				report($sformatf("%s: got %0d, want %0d", field, got, want));
		endtask

		// Match one result transfer against the oldest owed result.
		task check_result(logic [79:0] data, logic [1:0] user, logic last);
			result_t want;
			if (due_results.size() == 0) begin
				report("result transfer with no tick outstanding");
				return;
			end
			want = due_results.pop_front();
			compare("pressure",        $signed(data[10:0]),  want.pressure);
			compare("phase",           user,                 want.phase);
			compare("blower_angle",    data[18:11],          want.blower_angle);
			compare("blower_update",   data[19],             want.blower_update);
			compare("patient_angle",   data[27:20],          want.patient_angle);
			compare("patient_update",  data[28],             want.patient_update);
			compare("peak_capture",    $signed(data[39:29]), want.peak);
			compare("plateau_capture", $signed(data[50:40]), want.plateau);
			compare("pep_capture",     $signed(data[61:51]), want.pep);
			compare("tick_index",      data[72:62],          want.tick);
			compare("cycle_end",       last,                 want.cycle_end);
		endtask

		function int pending();
			return due_results.size();
		endfunction

		function bit at_cycle_start();
			return tick_cnt == 0;
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Block under test
	// ------------------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [9:0] pressure_sample
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// [10:0] pressure, [18:11] blower_angle, [19] blower_update,
	// [27:20] patient_angle, [28] patient_update, [39:29] peak_capture,
	// [50:40] plateau_capture, [61:51] pep_capture, [72:62] tick_index
	logic [79:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;   // [1:0] phase
	logic        m_axis_tlast;   // cycle_end

	ventilator_breath_cycle_controller_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	breath_scoreboard sb = new();

	int send_idle_pct;
	int recv_idle_pct;
	int cycle_count = 0;

	// Pressure trace state: segments of rising, steady and falling pressure
	// around the clinically interesting band, broken up by noise.
	int    wave_level = 200;
	int    wave_left  = 0;
	wave_e wave_mode  = WAVE_STEADY;

	// Directed burst: zero crossing, peak override, full-scale extremes,
	// falling pressure into the inspiratory hold with plateau override,
	// then pressures below the PEP minimum.
	logic [9:0] directed_samples [24] = '{
		10'd194, 10'd210, 10'd230, 10'd250, 10'd270, 10'd300,
		10'd1023, 10'd1000, 10'd260, 10'd255, 10'd250, 10'd240,
		10'd200, 10'd198, 10'd0, 10'd193, 10'd195, 10'd512,
		10'd1023, 10'd511, 10'd256, 10'd341, 10'd682, 10'd220
	};

	// ------------------------------------------------------------------------
	// Clock, watchdog, receiver stalls and result monitor
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Give up if the run hangs; a correct run ends far earlier.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ventilator_breath_cycle_controller_top: mismatch");
		$finish;
	end

	// Stall the result stream at random; drive at the falling edge.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Sample at the rising edge: a result transfer completes here.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	function automatic logic [9:0] next_sample();
		int roll;
		if (wave_left == 0) begin
			roll = $urandom_range(99);
			if (roll < 35)
				wave_mode = WAVE_RISE;
			else if (roll < 65)
				wave_mode = WAVE_STEADY;
			else if (roll < 90)
				wave_mode = WAVE_FALL;
			else
				wave_mode = WAVE_NOISE;
			wave_left = $urandom_range(3, 50);
		end
		wave_left--;
		case (wave_mode)
			WAVE_RISE:   wave_level = wave_level + int'($urandom_range(0, 5));
			WAVE_STEADY: wave_level = wave_level + int'($urandom_range(0, 2)) - 1;
			WAVE_FALL:   wave_level = wave_level - int'($urandom_range(0, 5));
			default:     return 10'($urandom_range(0, 1023));
		endcase
		if (wave_level < 170)
			wave_level = 170;
		if (wave_level > 330)
			wave_level = 330;
		return wave_level[9:0];
	endfunction

	// Offer one tick; return at the falling edge after its transfer with
	// tvalid still high so back-to-back ticks need no gap.
	task automatic send_tick(logic [9:0] sample);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {6'd0, sample};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.predict_tick(sample);
		@(negedge clk);
	endtask

	// Drop tvalid and hold until every owed result has come out.
	task automatic settle();
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [7:0] value);
		cfg_wen   = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_wen = 1'b0;
		sb.set_reg(idx, value);
	endtask

	task automatic write_all(int rate, int opening, int peak_lim, int plat_lim,
	                         int pep_min, int exp_angle);
		write_reg(CFG_RATE,      rate[7:0]);
		write_reg(CFG_OPENING,   opening[7:0]);
		write_reg(CFG_PEAK_LIM,  peak_lim[7:0]);
		write_reg(CFG_PLAT_LIM,  plat_lim[7:0]);
		write_reg(CFG_PEP_MIN,   pep_min[7:0]);
		write_reg(CFG_EXP_ANGLE, exp_angle[7:0]);
	endtask

	// Stream random ticks until the breathing cycle wraps, or the cap.
	task automatic run_cycle(int cap);
		int n;
		n = 0;
		do begin
			send_tick(next_sample());
			n++;
		end while (!sb.at_cycle_start() && n < cap);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		cfg_wen       = 1'b0;
		cfg_index     = CFG_RATE;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		send_idle_pct = 20;
		recv_idle_pct = 53;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Rate above the legal range must saturate to the fastest cycle.
		write_reg(CFG_RATE, 8'd63);
		foreach (directed_samples[i])
			send_tick(directed_samples[i]);

		// Finish the first cycle; peak limit and expiration angle act at once,
		// an expiration angle at the top of the servo range.
		settle();
		write_all(35, 45, 70, 30, 5, 180);
		run_cycle(1300);

		// Tight limits: blower closes on almost every tick, PEP floor high,
		// valve fully over on expiration.
		settle();
		write_all(63, 8, 10, 10, 30, 0);
		run_cycle(1300);

		// Swap idling: sender busy, receiver mostly ready.
		send_idle_pct = 53;
		recv_idle_pct = 20;

		// Register maxima but for the rate, expiration angle beyond the servo range.
		settle();
		write_all(34, 63, 127, 31, 31, 255);
		run_cycle(1300);

		// No idling; rate of zero saturates to the slowest cycle, all limits
		// at zero so long inspiratory holds drive the angles to their stops.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		settle();
		write_all(0, 0, 0, 0, 0, 90);
		repeat (100) send_tick(next_sample());

		settle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.errors == 0)
			$display("ventilator_breath_cycle_controller_top: match");
		else
			$display("ventilator_breath_cycle_controller_top: mismatch");
		$finish;
	end

endmodule
